[rtl/utr_pkg.sv]
package utr_pkg;

    // Widths of the decoder state.
    localparam int CODE_W = 21;
    localparam int PEND_W = 2;

    // Number of results that one byte can cause, and the depth of the result queue.
    localparam int MAX_RESULTS = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

    // Replacement character for anything that cannot be transcoded.
    localparam logic [7:0] QMARK = 8'h3F;

    // Index of each entry plus 0x80 gives the MacRoman byte.
    localparam logic [15:0] MAC_TABLE [128] = '{
        16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
        16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
        16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
        16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
        16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
        16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
        16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
        16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
        16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
        16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
        16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
        16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
        16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
        16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
        16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
        16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
    };

    // One result item.
    typedef struct packed {
        logic [7:0] mac_byte;
        logic       substituted;
        logic       run_last;
    } result_t;

    // Decoder state carried from byte to byte.
    typedef struct packed {
        logic [CODE_W-1:0] code_accum;
        logic [PEND_W-1:0] bytes_pending;
    } state_t;

    // All results caused by one byte, in order.
    typedef struct packed {
        logic [RCNT_W-1:0] count;
        result_t           res0;
        result_t           res1;
    } decode_t;

    // Table match of a code point.
    typedef struct packed {
        logic       hit;
        logic [6:0] idx;
    } lookup_t;

    // Compare the code point against every table entry in parallel.
    function automatic lookup_t mac_lookup(input logic [CODE_W-1:0] cp);
        lookup_t r;
        r.hit = 1'b0;
        r.idx = '0;
        for (int i = 0; i < 128; i++)
        begin
            if (cp == {{(CODE_W-16){1'b0}}, MAC_TABLE[i]})
            begin
                r.hit = 1'b1;
                r.idx = 7'(i);
            end
        end
        return r;
    endfunction

endpackage

[rtl/utr_in_if.sv]
interface utr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

[rtl/utr_out_if.sv]
interface utr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] mac_byte;
    logic       substituted;
    logic       run_last;

    modport source (output valid, output mac_byte, output substituted, output run_last,
                    input ready);
    modport sink   (input valid, input mac_byte, input substituted, input run_last,
                    output ready);
endinterface

[rtl/utr_decoder.sv]
module utr_decoder (
    input  logic [7:0]       data_byte,
    input  logic             stream_end,
    input  utr_pkg::state_t  cur_state,
    output utr_pkg::state_t  next_state,
    output utr_pkg::decode_t results
);
    import utr_pkg::*;

    // Outcome of handling a byte with no sequence open.
    typedef struct packed {
        logic    emit;
        result_t res;
        state_t  st;
    } lead_t;

    function automatic lead_t lead_decode(input logic [7:0] c, input state_t st_in);
        lead_t r;
        r.emit = 1'b0;
        r.res  = '{mac_byte: QMARK, substituted: 1'b1, run_last: 1'b0};
        r.st   = st_in;
        unique case (c) inside
            8'b0???_????:
            begin
                r.emit = 1'b1;
                r.res  = '{mac_byte: c, substituted: 1'b0, run_last: 1'b0};
            end
            8'b110?_????:
            begin
                r.st.code_accum    = {{(CODE_W-5){1'b0}}, c[4:0]};
                r.st.bytes_pending = PEND_W'(1);
            end
            8'b1110_????:
            begin
                r.st.code_accum    = {{(CODE_W-4){1'b0}}, c[3:0]};
                r.st.bytes_pending = PEND_W'(2);
            end
            8'b1111_0???:
            begin
                r.st.code_accum    = {{(CODE_W-3){1'b0}}, c[2:0]};
                r.st.bytes_pending = PEND_W'(3);
            end
            default:
            begin
                r.emit = 1'b1;
            end
        endcase
        return r;
    endfunction

    // Map a finished code point to a MacRoman byte.
    function automatic result_t code_result(input logic [CODE_W-1:0] cp);
        result_t r;
        lookup_t lk;
        lk = mac_lookup(cp);
        if (cp[CODE_W-1:7] == '0)
        begin
            r = '{mac_byte: {1'b0, cp[6:0]}, substituted: 1'b0, run_last: 1'b0};
        end
        else if (lk.hit)
        begin
            r = '{mac_byte: {1'b1, lk.idx}, substituted: 1'b0, run_last: 1'b0};
        end
        else
        begin
            r = '{mac_byte: QMARK, substituted: 1'b1, run_last: 1'b0};
        end
        return r;
    endfunction

    localparam result_t SUB_RES = '{mac_byte: QMARK, substituted: 1'b1, run_last: 1'b0};

    lead_t             lead;
    state_t            st;
    logic [CODE_W-1:0] acc_new;
    logic [PEND_W-1:0] pend_new;
    logic              a_v;
    logic              b_v;
    logic              e_v;
    result_t           b_res;
    result_t           r0;
    result_t           r1;
    logic [RCNT_W-1:0] cnt;

    // Up to three candidate results: broken sequence, byte result, open at end.
    always_comb
    begin
        acc_new  = {cur_state.code_accum[CODE_W-7:0], data_byte[5:0]};
        pend_new = cur_state.bytes_pending - PEND_W'(1);
        st       = cur_state;
        a_v      = 1'b0;
        b_v      = 1'b0;
        b_res    = SUB_RES;

        if (cur_state.bytes_pending == '0)
        begin
            lead  = lead_decode(data_byte, cur_state);
            b_v   = lead.emit;
            b_res = lead.res;
            st    = lead.st;
        end
        else if (data_byte[7:6] == 2'b10)
        begin
            lead             = lead_decode(data_byte, cur_state);
            st.bytes_pending = pend_new;
            if (pend_new == '0)
            begin
                b_v           = 1'b1;
                b_res         = code_result(acc_new);
                st.code_accum = '0;
            end
            else
            begin
                st.code_accum = acc_new;
            end
        end
        else
        begin
            // The broken sequence gives a substitute result and the byte starts over as a lead.
            a_v   = 1'b1;
            lead  = lead_decode(data_byte, '0);
            b_v   = lead.emit;
            b_res = lead.res;
            st    = lead.st;
        end

        e_v = stream_end && (st.bytes_pending != '0);
        if (stream_end)
        begin
            st = '0;
        end
        next_state = st;
    end

    // Pack the valid candidates in order and mark the last one.
    always_comb
    begin
        cnt = RCNT_W'({1'b0, a_v}) + RCNT_W'({1'b0, b_v}) + RCNT_W'({1'b0, e_v});
        if (a_v)
        begin
            r0 = SUB_RES;
            r1 = b_v ? b_res : SUB_RES;
        end
        else
        begin
            r0 = b_v ? b_res : SUB_RES;
            r1 = SUB_RES;
        end
        r0.run_last     = (cnt == RCNT_W'(1));
        r1.run_last     = (cnt == RCNT_W'(2));
        results.count   = cnt;
        results.res0    = r0;
        results.res1    = r1;
    end

endmodule

[rtl/utr_out_queue.sv]
module utr_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  utr_pkg::decode_t  results,
    output logic              space_ok,
    utr_out_if.source         mac_stream
);
    import utr_pkg::*;

    result_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic [RCNT_W-1:0] n_push;
    logic              pop;

    // A request is taken only when the queue can hold every result it may cause.
    assign space_ok = (count_reg <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS));

    assign n_push = push ? results.count : '0;
    assign pop    = mac_stream.valid && mac_stream.ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(n_push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage; the second result goes to the slot after the first.
    always_ff @(posedge clk)
    begin
        if (n_push != '0)
        begin
            entry_reg[wr_ptr_reg] <= results.res0;
        end
        if (n_push == RCNT_W'(2))
        begin
            entry_reg[wr_ptr_reg + QPTR_W'(1)] <= results.res1;
        end
    end

    assign mac_stream.valid       = (count_reg != '0);
    assign mac_stream.mac_byte    = entry_reg[rd_ptr_reg].mac_byte;
    assign mac_stream.substituted = entry_reg[rd_ptr_reg].substituted;
    assign mac_stream.run_last    = entry_reg[rd_ptr_reg].run_last;

endmodule

[rtl/utr_to_mac_roman_transcoder.sv]
// A result is offered once its byte has passed the input register and the result queue.
// Throughput: one byte per cycle while the queue has room; the output gives one result
// per cycle while ready is high; a four-entry queue absorbs bytes with two results.
// Byte accept stalls only when that queue holds more than two results.
// Reset (rst_n low, asynchronous) closes any open sequence and empties the queue.
module utf8_to_mac_roman_transcoder (
    input  logic     clk,
    input  logic     rst_n,
    utr_in_if.sink   byte_stream,
    utr_out_if.source mac_stream
);
    import utr_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_end_reg;
    state_t     state_reg;
    state_t     state_next;
    decode_t    results;
    logic       space_ok;
    logic       s1_fire;

    // The input register moves into the decoder whenever the queue has room.
    assign s1_fire           = s1_valid_reg && space_ok;
    assign byte_stream.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            if (byte_stream.ready)
            begin
                s1_valid_reg <= byte_stream.valid;
            end
            if (s1_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (byte_stream.valid && byte_stream.ready)
        begin
            s1_byte_reg <= byte_stream.data_byte;
            s1_end_reg  <= byte_stream.stream_end;
        end
    end

    utr_decoder u_decoder (
        .data_byte  (s1_byte_reg),
        .stream_end (s1_end_reg),
        .cur_state  (state_reg),
        .next_state (state_next),
        .results    (results)
    );

    utr_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s1_fire),
        .results    (results),
        .space_ok   (space_ok),
        .mac_stream (mac_stream)
    );

`ifndef SYNTHESIS
    // A request held back by a full queue keeps its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_byte_reg))
        else $error("held input request changed");

    // With no sequence open there is no partial code point.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.bytes_pending == '0) |-> (state_reg.code_accum == '0))
        else $error("code point left over with no sequence open");

    // The end of a stream always leaves the decoder in its reset state.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_end_reg |=> (state_reg == '0))
        else $error("state not cleared at end of stream");
`endif

endmodule
